[hw/rtl/double_ended_queue_top_defines.svh]
// Assertion macros for the deque RTL, used by deq_ctrl
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define DEQ_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// same-cycle implication
`define DEQ_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

[hw/rtl/deq_pkg.sv]
// Types, constants and codes for the deque cell chain
package deq_pkg;

   localparam int DEPTH      = 256;
   localparam int ITEM_WIDTH = 32;

   localparam int DATA_W     = 32;
   localparam int SLOT_W     = 9;
   localparam int HELD_W     = 9;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMP_W      = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET = SLOT_W'(256);

   // request codes
   localparam logic [1:0] OP_PUSH_TOP = 2'd0;
   localparam logic [1:0] OP_PUSH_BOT = 2'd1;
   localparam logic [1:0] OP_POP_TOP  = 2'd2;
   localparam logic [1:0] OP_POP_BOT  = 2'd3;

   // register index, taken from paddr[2]
   localparam logic [0:0] REG_SLOT_COUNT = 1'b0;
   localparam logic [0:0] REG_QUEUE_OPEN = 1'b1;

   typedef logic [ITEM_WIDTH-1:0] item_type;

   // what every cell shows its two neighbours
   typedef struct packed {
      item_type data;
      logic     lo;    // member of the bottom run, anchored at cell 0
      logic     hi;    // member of the top run, anchored at the last cell
   } link_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LO_UP,
      CELL_LO_DN,
      CELL_HI_UP,
      CELL_HI_DN,
      CELL_SWAP,
      CELL_CLEAR
   } cell_cmd_type;

   // state of the two end cells, seen by the controller
   typedef struct packed {
      logic     lo_first;
      logic     hi_first;
      logic     lo_last;
      logic     hi_last;
      item_type data_first;
      item_type data_last;
   } ends_type;

endpackage

[hw/rtl/double_ended_queue_top.sv]
// Deque top level: sequencer and the chain of storage cells
//
//   channel   direction   beat
//   req       in          req_op, req_push_data
//   rsp       out         rsp_pop_data, rsp_failed, rsp_items_held, rsp_is_empty
//   csr       in/out      APB write/read of slot_count (0x0) and queue_open (0x4)
//
// A push, a failed request, or a pop at an end whose run is occupied is done in ST_IDLE.
// A pop from an end whose run is empty slides the other run along the chain one cell a
// cycle first, swaps the run flags once it reaches that end, then pops in ST_FINISH.
// Reset clears the run flags of every cell at once; stored data is left as it was.
// req_stall is high while a request is in work or a result beat waits under rsp_stall.
module double_ended_queue_top
   import deq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [DATA_W-1:0]     req_push_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_W-1:0]     rsp_pop_data,
   output logic                  rsp_failed,
   output logic [HELD_W-1:0]     rsp_items_held,
   output logic                  rsp_is_empty,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   link_type     cell_q [DEPTH];
   link_type     bound_lo;
   link_type     bound_hi;
   cell_cmd_type cell_cmd;
   ends_type     ends;

   assign ends.lo_first   = cell_q[0].lo;
   assign ends.hi_first   = cell_q[0].hi;
   assign ends.lo_last    = cell_q[DEPTH-1].lo;
   assign ends.hi_last    = cell_q[DEPTH-1].hi;
   assign ends.data_first = cell_q[0].data;
   assign ends.data_last  = cell_q[DEPTH-1].data;

   deq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_push_data  (req_push_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pop_data   (rsp_pop_data),
      .rsp_failed     (rsp_failed),
      .rsp_items_held (rsp_items_held),
      .rsp_is_empty   (rsp_is_empty),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .ends           (ends),
      .cell_cmd       (cell_cmd),
      .bound_lo       (bound_lo),
      .bound_hi       (bound_hi)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      link_type below;
      link_type above;

      if (i == 0) begin : g_first
         assign below = bound_lo;
      end else begin : g_mid_lo
         assign below = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign above = bound_hi;
      end else begin : g_mid_hi
         assign above = cell_q[i+1];
      end

      deq_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cell_cmd),
         .below (below),
         .above (above),
         .q     (cell_q[i])
      );
   end

endmodule

[hw/rtl/deq_cell.sv]
// One storage cell of the deque chain
module deq_cell
   import deq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  link_type     below,
   input  link_type     above,
   output link_type     q
);

   item_type data_ff, data_in;
   logic     lo_ff, lo_in;
   logic     hi_ff, hi_in;

   always_comb begin
      data_in = data_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      case (cmd)
         CELL_LO_UP: begin
            lo_in = below.lo;
            if (below.lo) begin
               data_in = below.data;
            end
         end
         CELL_LO_DN: begin
            lo_in = above.lo;
            if (above.lo) begin
               data_in = above.data;
            end
         end
         CELL_HI_UP: begin
            hi_in = below.hi;
            if (below.hi) begin
               data_in = below.data;
            end
         end
         CELL_HI_DN: begin
            hi_in = above.hi;
            if (above.hi) begin
               data_in = above.data;
            end
         end
         CELL_SWAP: begin
            lo_in = hi_ff;
            hi_in = lo_ff;
         end
         CELL_CLEAR: begin
            lo_in = 1'b0;
            hi_in = 1'b0;
         end
         CELL_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= 1'b0;
         hi_ff <= 1'b0;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q.data = data_ff;
   assign q.lo   = lo_ff;
   assign q.hi   = hi_ff;

endmodule

[hw/rtl/deq_ctrl.sv]
// Request sequencer, fill count, registers and result stage of the deque
`include "double_ended_queue_top_defines.svh"

module deq_ctrl
   import deq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [DATA_W-1:0]     req_push_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_W-1:0]     rsp_pop_data,
   output logic                  rsp_failed,
   output logic [HELD_W-1:0]     rsp_items_held,
   output logic                  rsp_is_empty,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  ends_type              ends,
   output cell_cmd_type          cell_cmd,
   output link_type              bound_lo,
   output link_type              bound_hi
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN_DN,
      ST_DRAIN_UP,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]  slot_count_ff, slot_count_in;
   logic               queue_open_ff, queue_open_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_pop_data_ff;
   logic               rsp_failed_ff;
   logic [HELD_W-1:0]  rsp_items_held_ff;
   logic               rsp_is_empty_ff;

   logic               accept;
   logic               csr_wr;
   logic               is_push;
   logic               full;
   logic [CMP_W-1:0]   slot_ext;
   logic [CMP_W-1:0]   n_slots;
   logic [CMP_W-1:0]   fill_ext;
   logic               ins_lo;
   logic               ins_hi;
   logic               emit;
   logic               res_fail;
   logic [DATA_W-1:0]  res_data;
   logic               do_pop;
   logic               pop_top_sel;
   item_type           push_item;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;
   assign is_push   = req_op inside {OP_PUSH_TOP, OP_PUSH_BOT};

   // zero slots behaves as one, anything above the store saturates
   assign slot_ext = CMP_W'(slot_count_ff);
   assign n_slots  = (slot_ext == '0)             ? CMP_W'(1)     :
                     (slot_ext > CMP_W'(DEPTH))   ? CMP_W'(DEPTH) : slot_ext;
   assign fill_ext = CMP_W'(fill_ff);
   assign full     = fill_ext >= n_slots;

   assign push_item = item_type'(req_push_data);

   assign bound_lo.data = push_item;
   assign bound_lo.lo   = ins_lo;
   assign bound_lo.hi   = 1'b0;
   assign bound_hi.data = push_item;
   assign bound_hi.lo   = 1'b0;
   assign bound_hi.hi   = ins_hi;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      fill_in       = fill_ff;
      slot_count_in = slot_count_ff;
      queue_open_in = queue_open_ff;
      cell_cmd      = CELL_HOLD;
      ins_lo        = 1'b0;
      ins_hi        = 1'b0;
      emit          = 1'b0;
      res_fail      = 1'b0;
      res_data      = '0;
      do_pop        = 1'b0;
      pop_top_sel   = 1'b0;

      if (csr_wr) begin
         // any register write empties the deque
         cell_cmd = CELL_CLEAR;
         fill_in  = '0;
         state_in = ST_IDLE;
         case (csr_paddr[2])
            REG_SLOT_COUNT: slot_count_in = csr_pwdata[SLOT_W-1:0];
            REG_QUEUE_OPEN: queue_open_in = csr_pwdata[0];
            default: begin
            end
         endcase
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_in = req_op;
                  if (!queue_open_ff || (is_push && full) || (!is_push && fill_ff == '0)) begin
                     emit     = 1'b1;
                     res_fail = 1'b1;
                  end else begin
                     case (req_op)
                        OP_PUSH_TOP: begin
                           cell_cmd = CELL_HI_DN;
                           ins_hi   = 1'b1;
                           fill_in  = fill_ff + CNT_W'(1);
                           emit     = 1'b1;
                        end
                        OP_PUSH_BOT: begin
                           cell_cmd = CELL_LO_UP;
                           ins_lo   = 1'b1;
                           fill_in  = fill_ff + CNT_W'(1);
                           emit     = 1'b1;
                        end
                        OP_POP_TOP: begin
                           if (ends.hi_last) begin
                              do_pop      = 1'b1;
                              pop_top_sel = 1'b1;
                           end else begin
                              state_in = ST_DRAIN_UP;
                           end
                        end
                        OP_POP_BOT: begin
                           if (ends.lo_first) begin
                              do_pop = 1'b1;
                           end else begin
                              state_in = ST_DRAIN_DN;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            // top run slides down until it reaches cell 0, then becomes the bottom run
            ST_DRAIN_DN: begin
               if (ends.hi_first) begin
                  cell_cmd = CELL_SWAP;
                  state_in = ST_FINISH;
               end else begin
                  cell_cmd = CELL_HI_DN;
               end
            end
            ST_DRAIN_UP: begin
               if (ends.lo_last) begin
                  cell_cmd = CELL_SWAP;
                  state_in = ST_FINISH;
               end else begin
                  cell_cmd = CELL_LO_UP;
               end
            end
            ST_FINISH: begin
               do_pop      = 1'b1;
               pop_top_sel = (op_ff == OP_POP_TOP);
               state_in    = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase

         if (do_pop) begin
            emit    = 1'b1;
            fill_in = fill_ff - CNT_W'(1);
            if (pop_top_sel) begin
               cell_cmd = CELL_HI_UP;
               res_data = DATA_W'(ends.data_last);
            end else begin
               cell_cmd = CELL_LO_DN;
               res_data = DATA_W'(ends.data_first);
            end
         end
      end

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         slot_count_ff <= SLOT_COUNT_RESET;
         queue_open_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         slot_count_ff <= slot_count_in;
         queue_open_ff <= queue_open_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff <= op_in;
      if (emit) begin
         rsp_pop_data_ff   <= res_data;
         rsp_failed_ff     <= res_fail;
         rsp_items_held_ff <= HELD_W'(fill_in);
         rsp_is_empty_ff   <= (fill_in == '0);
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SLOT_COUNT: csr_prdata = CSR_DATA_W'(slot_count_ff);
         REG_QUEUE_OPEN: csr_prdata = CSR_DATA_W'(queue_open_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign csr_pready     = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pop_data   = rsp_pop_data_ff;
   assign rsp_failed     = rsp_failed_ff;
   assign rsp_items_held = rsp_items_held_ff;
   assign rsp_is_empty   = rsp_is_empty_ff;

   `DEQ_ASSERT_ALWAYS(a_fill_in_range, clock, reset, fill_ext <= n_slots, "fill beyond slot count")
   `DEQ_ASSERT_IMPLY(a_fail_zero_data, clock, reset, rsp_valid_ff && rsp_failed_ff, rsp_pop_data_ff == '0, "failed beat carries data")
   `DEQ_ASSERT_IMPLY(a_drain_not_empty, clock, reset, state_ff == ST_DRAIN_DN || state_ff == ST_DRAIN_UP, fill_ff != '0, "drain on empty deque")
   `DEQ_ASSERT_IMPLY(a_empty_no_runs, clock, reset, state_ff == ST_IDLE && fill_ff == '0, !ends.lo_first && !ends.hi_last, "empty deque with occupied end cell")

endmodule

[sim/double_ended_queue_top_tb.sv]
// Self-checking testbench for the cell-chain deque with its APB register port
`timescale 1ns / 100ps

module double_ended_queue_top_tb
   import deq_pkg::*;
();

   localparam int STUCK_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 300;
   localparam logic [CSR_ADDR_W-1:0] SLOT_COUNT_ADDR = {REG_SLOT_COUNT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] QUEUE_OPEN_ADDR = {REG_QUEUE_OPEN, 2'b00};

   typedef struct packed {
      logic [DATA_W-1:0] pop_data;
      logic              failed;
      logic [HELD_W-1:0] items_held;
      logic              is_empty;
   } deque_result_type;

   // shadow deque: predicts each result beat and holds the ones still due
   class deque_shadow_type;
      item_type          slots [DEPTH];
      int unsigned       top_slot;
      int unsigned       bottom_slot;
      int unsigned       fill;
      logic [SLOT_W-1:0] slot_count;
      logic              queue_open;
      deque_result_type  due_results [$];
      int                errors;

      function new();
         slot_count = SLOT_COUNT_RESET;
         queue_open = 1'b1;
         top_slot = 0;
         bottom_slot = 0;
         fill = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [0:0] index, logic [CSR_DATA_W-1:0] value);
         if (index == REG_SLOT_COUNT) begin
            slot_count = value[SLOT_W-1:0];
         end else begin
            queue_open = value[0];
         end
         top_slot = 0;
         bottom_slot = 0;
         fill = 0;
      endfunction

      function logic [CSR_DATA_W-1:0] reg_value(logic [0:0] index);
         if (index == REG_SLOT_COUNT) begin
            return CSR_DATA_W'(slot_count);
         end
         return CSR_DATA_W'(queue_open);
      endfunction

      function int unsigned ring_size();
         int unsigned n;
         n = slot_count;
         if (n == 0) n = 1;
         if (n > DEPTH) n = DEPTH;
         return n;
      endfunction

      function void apply_request(logic [1:0] op, logic [DATA_W-1:0] data);
         int unsigned      n;
         deque_result_type res;
         n = ring_size();
         res = '0;
         top_slot = top_slot % n;
         bottom_slot = bottom_slot % n;
         if (!queue_open) begin
            res.failed = 1'b1;
         end else if (op == OP_PUSH_TOP || op == OP_PUSH_BOT) begin
            if (fill >= n) begin
               res.failed = 1'b1;
            end else begin
               if (op == OP_PUSH_TOP) begin
                  if (fill != 0) top_slot = (top_slot + 1) % n;
                  slots[top_slot] = item_type'(data);
               end else begin
                  if (fill != 0) bottom_slot = (bottom_slot + n - 1) % n;
                  slots[bottom_slot] = item_type'(data);
               end
               fill++;
            end
         end else if (fill == 0) begin
            res.failed = 1'b1;
         end else begin
            // a lone item sits under both indices, so neither moves
            if (op == OP_POP_TOP) begin
               res.pop_data = DATA_W'(slots[top_slot]);
               if (fill != 1) top_slot = (top_slot + n - 1) % n;
            end else begin
               res.pop_data = DATA_W'(slots[bottom_slot]);
               if (fill != 1) bottom_slot = (bottom_slot + 1) % n;
            end
            fill--;
         end
         res.items_held = HELD_W'(fill);
         res.is_empty = (fill == 0);
         due_results.push_back(res);
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      task report(string what);
         $display("%0t mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic [DATA_W-1:0] pop_data, logic failed,
                        logic [HELD_W-1:0] held, logic empty);
         deque_result_type want;
         if (due_results.size() == 0) begin
            report($sformatf("result beat with nothing due (pop_data %h failed %b)",
                             pop_data, failed));
            return;
         end
         want = due_results.pop_front();
         if (pop_data !== want.pop_data)
            report($sformatf("pop_data %h, want %h", pop_data, want.pop_data));
         if (failed !== want.failed)
            report($sformatf("failed %b, want %b", failed, want.failed));
         if (held !== want.items_held)
            report($sformatf("items_held %0d, want %0d", held, want.items_held));
         if (empty !== want.is_empty)
            report($sformatf("is_empty %b, want %b", empty, want.is_empty));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_op;
   logic [DATA_W-1:0]     req_push_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [DATA_W-1:0]     rsp_pop_data;
   logic                  rsp_failed;
   logic [HELD_W-1:0]     rsp_items_held;
   logic                  rsp_is_empty;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   deque_shadow_type shadow;
   bit               no_gaps;
   int               stall_left;
   int               stuck_cycles;

   double_ended_queue_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_push_data  (req_push_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pop_data   (rsp_pop_data),
      .rsp_failed     (rsp_failed),
      .rsp_items_held (rsp_items_held),
      .rsp_is_empty   (rsp_is_empty),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: after each beat, hold stall for a drawn number of cycles
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         stall_left = no_gaps ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
      end
      rsp_stall <= (stall_left > 0);
   end

   // beat monitor and watchdog; requests noted before results in case both land together
   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            shadow.apply_request(req_op, req_push_data);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            shadow.check_result(rsp_pop_data, rsp_failed, rsp_items_held, rsp_is_empty);
            moved = 1'b1;
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) shadow.write_reg(csr_paddr[2], csr_pwdata);
            moved = 1'b1;
         end
         stuck_cycles = moved ? 0 : stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("double_ended_queue_top regression: fail");
            $finish;
         end
      end
   end

   task automatic send_req(logic [1:0] op, logic [DATA_W-1:0] data);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_push_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // register access only once every due beat is back
   task automatic csr_access(bit write, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] wdata);
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.pending() != 0 || req_stall) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (!write && csr_prdata !== shadow.reg_value(addr[2]))
         shadow.report($sformatf("prdata %h at %h, want %h", csr_prdata, addr,
                                 shadow.reg_value(addr[2])));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // upper data bits carry noise; only the register's own bits should stick
   task automatic set_deque(logic [SLOT_W-1:0] slots, logic open);
      logic [CSR_DATA_W-1:0] noise;
      noise = $urandom;
      csr_access(1'b1, SLOT_COUNT_ADDR, {noise[CSR_DATA_W-1:SLOT_W], slots});
      noise = $urandom;
      csr_access(1'b1, QUEUE_OPEN_ADDR, {noise[CSR_DATA_W-1:1], open});
      csr_access(1'b0, SLOT_COUNT_ADDR, '0);
      csr_access(1'b0, QUEUE_OPEN_ADDR, '0);
   endtask

   task automatic run_phase(logic [SLOT_W-1:0] slots, logic open, int count, bit fill_first);
      int                bias;
      logic [1:0]        op;
      logic [DATA_W-1:0] data;
      set_deque(slots, open);
      bias = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
               0: bias = 15;
               1: bias = 50;
               default: bias = 85;
            endcase
         end
         // fill to the brim, then drain
         if (fill_first) bias = (i < count / 2) ? 97 : 10;
         if ($urandom_range(0, 99) < bias) begin
            op = $urandom_range(0, 1) ? OP_PUSH_TOP : OP_PUSH_BOT;
         end else begin
            op = $urandom_range(0, 1) ? OP_POP_TOP : OP_POP_BOT;
         end
         case ($urandom_range(0, 9))
            0: data = '0;
            1: data = '1;
            default: data = $urandom;
         endcase
         send_req(op, data);
      end
   endtask

   initial begin
      shadow = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_PUSH_TOP;
      req_push_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      no_gaps = 1'b0;
      stall_left = 0;
      stuck_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty pops, both ends, down to a single item
      csr_access(1'b0, SLOT_COUNT_ADDR, '0);
      csr_access(1'b0, QUEUE_OPEN_ADDR, '0);
      send_req(OP_POP_TOP, $urandom);
      send_req(OP_POP_BOT, $urandom);
      send_req(OP_PUSH_TOP, '0);
      send_req(OP_PUSH_TOP, '1);
      send_req(OP_PUSH_BOT, 32'hA5A5_A5A5);
      send_req(OP_POP_TOP, $urandom);
      send_req(OP_POP_TOP, $urandom);
      send_req(OP_POP_TOP, $urandom);
      send_req(OP_PUSH_BOT, 32'h5A5A_5A5A);
      send_req(OP_POP_BOT, $urandom);

      // a register write throws away what is held; one slot fills at once
      send_req(OP_PUSH_TOP, $urandom);
      csr_access(1'b1, SLOT_COUNT_ADDR, 1);
      send_req(OP_POP_BOT, $urandom);
      send_req(OP_PUSH_BOT, $urandom);
      send_req(OP_PUSH_TOP, $urandom);
      send_req(OP_POP_TOP, $urandom);

      // zero slots behaves as one
      csr_access(1'b1, SLOT_COUNT_ADDR, 0);
      send_req(OP_PUSH_TOP, $urandom);
      send_req(OP_PUSH_BOT, $urandom);

      // two slots: bottom index wraps below zero
      csr_access(1'b1, SLOT_COUNT_ADDR, 2);
      send_req(OP_PUSH_BOT, $urandom);
      send_req(OP_PUSH_BOT, $urandom);
      send_req(OP_PUSH_TOP, $urandom);
      send_req(OP_POP_TOP, $urandom);
      send_req(OP_POP_TOP, $urandom);

      // closed deque refuses everything
      csr_access(1'b1, QUEUE_OPEN_ADDR, 0);
      send_req(OP_PUSH_TOP, $urandom);
      send_req(OP_POP_BOT, $urandom);

      run_phase(256, 1'b1, 600, 1'b1);
      run_phase(511, 1'b1, 150, 1'b0);
      run_phase(257, 1'b1, 100, 1'b0);
      run_phase(1, 1'b1, 60, 1'b0);
      run_phase(0, 1'b1, 40, 1'b0);
      run_phase(2, 1'b1, 80, 1'b0);
      run_phase(3, 1'b1, 80, 1'b0);
      run_phase(7, 1'b1, 100, 1'b0);
      repeat (4) run_phase(SLOT_W'($urandom_range(1, 16)), 1'b1, 80, 1'b0);
      run_phase(SLOT_W'($urandom_range(0, 511)), 1'b0, 30, 1'b0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.pending() != 0) @(posedge clock);
      // long enough for a slide along the whole chain
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.errors == 0) begin
         $display("double_ended_queue_top regression: pass");
      end else begin
         $display("double_ended_queue_top regression: fail");
      end
      $finish;
   end

endmodule
